### rtl/sts_pkg.sv
// sts_pkg: shared types and constants for the S-expression token scanner.
// Used by the scanner top level; no dependencies.

package sts_pkg;

  // Scan modes.
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_BARE   = 2'd1;
  localparam logic [1:0] MODE_QUOTED = 2'd2;
  localparam logic [1:0] MODE_ESCAPE = 2'd3;

  // Input word kinds.
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  // Token kinds on the result channel.
  localparam logic [2:0] TK_BYTE      = 3'd0;
  localparam logic [2:0] TK_WEND      = 3'd1;
  localparam logic [2:0] TK_OPEN      = 3'd2;
  localparam logic [2:0] TK_CLOSE     = 3'd3;
  localparam logic [2:0] TK_EOL       = 3'd4;
  localparam logic [2:0] TK_ERR_ESC   = 3'd5;
  localparam logic [2:0] TK_ERR_QUOTE = 3'd6;

  // Special characters.
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // One result word.
  typedef struct packed {
    logic [2:0] token_kind;
    logic [7:0] byte_value;
    logic [7:0] word_length;
    logic       last;
  } token_t;

endpackage

### rtl/sts_in_if.sv
// sts_in_if: valid/ready channel that carries one text byte or end-of-line mark.
// Depends on nothing but is used with the scanner top level.

interface sts_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_byte;

  modport source (output valid, output kind, output char_byte, input ready);
  modport sink   (input valid, input kind, input char_byte, output ready);
endinterface

### rtl/sts_out_if.sv
// sts_out_if: valid/ready channel that carries one scanner token.
// Field widths follow sts_pkg::token_t.

interface sts_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [7:0] byte_value;
  logic [7:0] word_length;
  logic       last;

  modport source (output valid, output token_kind, output byte_value,
                  output word_length, output last, input ready);
  modport sink   (input valid, input token_kind, input byte_value,
                  input word_length, input last, output ready);
endinterface

### rtl/sexpr_token_scanner.sv
// sexpr_token_scanner: streaming S-expression tokenizer for one line of text.
// Depends on sts_pkg, sts_in_if and sts_out_if.
//
//   channel   direction  words carried
//   in_chan   in         kind, char_byte (text byte or end of line)
//   out_chan  out        token_kind, byte_value, word_length, last
//
// Each accepted input word is decoded in the cycle it is taken: the scan
// mode and word count update at that edge, and the zero, one or two tokens
// it causes are written into a four-entry result queue.
// The result channel drains one token per cycle while out_chan.ready is high,
// so both sides run at one word per cycle if each word yields at most one token.
// Input is taken whenever the queue has room for two tokens; a stalled
// result side fills the queue and then holds off input, losing nothing.
// Reset (rst_n low, synchronous) empties the queue and returns to idle.

module sexpr_token_scanner #(
  parameter int MAX_WORD_LENGTH = 255
) (
  input  logic      clk,
  input  logic      rst_n,
  sts_in_if.sink    in_chan,
  sts_out_if.source out_chan
);

  // The word count saturates at the smaller of the parameter and 255.
  localparam logic [7:0] WORD_LIMIT =
      (MAX_WORD_LENGTH < 255) ? 8'(MAX_WORD_LENGTH) : 8'd255;
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // Scanner state.
  logic [1:0] mode_r, mode_nxt;
  logic [7:0] count_r, count_nxt;

  // Result queue.
  sts_pkg::token_t  q_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]     fill_r, fill_nxt;

  logic in_acc, out_acc;

  // Tokens produced by the current input word.
  sts_pkg::token_t res0, res1;
  logic [1:0]      n_res;

  // What a byte does when no word is open.
  sts_pkg::token_t st_res;
  logic            st_emit;
  logic [1:0]      st_mode;
  logic [7:0]      st_count;

  logic [7:0] count_inc;
  logic       is_delim;

  assign in_chan.ready = (fill_r <= (QAW+1)'(QDEPTH - 2));
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;

  assign count_inc = (count_r < WORD_LIMIT) ? count_r + 8'd1 : count_r;
  assign is_delim  = (in_chan.char_byte == sts_pkg::CH_SPACE) ||
                     (in_chan.char_byte == sts_pkg::CH_OPEN)  ||
                     (in_chan.char_byte == sts_pkg::CH_CLOSE) ||
                     (in_chan.char_byte == sts_pkg::CH_QUOTE);

  // Start of a token: spaces are dropped, parentheses are single tokens,
  // anything else opens a word whose first byte counts as one.
  always_comb begin
    st_res   = '0;
    st_emit  = 1'b1;
    st_mode  = sts_pkg::MODE_IDLE;
    st_count = 8'd0;
    if (in_chan.char_byte == sts_pkg::CH_SPACE) begin
      st_emit = 1'b0;
    end else if (in_chan.char_byte == sts_pkg::CH_OPEN) begin
      st_res.token_kind = sts_pkg::TK_OPEN;
    end else if (in_chan.char_byte == sts_pkg::CH_CLOSE) begin
      st_res.token_kind = sts_pkg::TK_CLOSE;
    end else begin
      st_res.token_kind = sts_pkg::TK_BYTE;
      st_res.byte_value = in_chan.char_byte;
      st_mode  = (in_chan.char_byte == sts_pkg::CH_QUOTE) ?
                 sts_pkg::MODE_QUOTED : sts_pkg::MODE_BARE;
      st_count = 8'd1;
    end
  end

  // Main decode: up to two tokens and the next scan state.
  always_comb begin
    res0      = '0;
    res1      = '0;
    n_res     = 2'd0;
    mode_nxt  = mode_r;
    count_nxt = count_r;
    if (in_chan.kind == sts_pkg::KIND_EOL) begin
      // End of line closes whatever is open, then reports the line end.
      res1.token_kind = sts_pkg::TK_EOL;
      n_res = 2'd2;
      case (mode_r)
        sts_pkg::MODE_BARE: begin
          res0.token_kind  = sts_pkg::TK_WEND;
          res0.word_length = count_r;
        end
        sts_pkg::MODE_QUOTED: res0.token_kind = sts_pkg::TK_ERR_QUOTE;
        sts_pkg::MODE_ESCAPE: res0.token_kind = sts_pkg::TK_ERR_ESC;
        default: begin
          res0  = res1;
          n_res = 2'd1;
        end
      endcase
      mode_nxt  = sts_pkg::MODE_IDLE;
      count_nxt = 8'd0;
    end else begin
      case (mode_r)
        sts_pkg::MODE_IDLE: begin
          res0      = st_res;
          n_res     = {1'b0, st_emit};
          mode_nxt  = st_mode;
          count_nxt = st_count;
        end
        sts_pkg::MODE_BARE: begin
          if (is_delim) begin
            // Word end, then the delimiter is handled as a fresh start.
            res0.token_kind  = sts_pkg::TK_WEND;
            res0.word_length = count_r;
            res1      = st_res;
            n_res     = st_emit ? 2'd2 : 2'd1;
            mode_nxt  = st_mode;
            count_nxt = st_count;
          end else begin
            res0.token_kind = sts_pkg::TK_BYTE;
            res0.byte_value = in_chan.char_byte;
            n_res     = 2'd1;
            count_nxt = count_inc;
          end
        end
        sts_pkg::MODE_QUOTED: begin
          res0.token_kind = sts_pkg::TK_BYTE;
          res0.byte_value = in_chan.char_byte;
          n_res     = 2'd1;
          count_nxt = count_inc;
          if (in_chan.char_byte == sts_pkg::CH_QUOTE) begin
            // Closing quote: its length includes both quotes.
            res1.token_kind  = sts_pkg::TK_WEND;
            res1.word_length = count_inc;
            n_res     = 2'd2;
            mode_nxt  = sts_pkg::MODE_IDLE;
            count_nxt = 8'd0;
          end else if (in_chan.char_byte == sts_pkg::CH_BSLASH) begin
            mode_nxt = sts_pkg::MODE_ESCAPE;
          end
        end
        default: begin
          // The byte after a backslash is taken literally.
          res0.token_kind = sts_pkg::TK_BYTE;
          res0.byte_value = in_chan.char_byte;
          n_res     = 2'd1;
          count_nxt = count_inc;
          mode_nxt  = sts_pkg::MODE_QUOTED;
        end
      endcase
    end
    // Mark the final token of this input word.
    if (n_res == 2'd2) begin
      res1.last = 1'b1;
    end else begin
      res0.last = 1'b1;
    end
  end

  // Queue pointer bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (in_acc) begin
      wr_ptr_nxt = wr_ptr_r + QAW'(n_res);
      fill_nxt   = fill_nxt + (QAW+1)'(n_res);
    end
    if (out_acc) begin
      rd_ptr_nxt = rd_ptr_r + QAW'(1);
      fill_nxt   = fill_nxt - (QAW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= sts_pkg::MODE_IDLE;
      count_r  <= 8'd0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
      if (in_acc) begin
        mode_r  <= mode_nxt;
        count_r <= count_nxt;
      end
    end
  end

  // Queue payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_acc && n_res != 2'd0) begin
      q_r[wr_ptr_r] <= res0;
    end
    if (in_acc && n_res == 2'd2) begin
      q_r[wr_ptr_r + QAW'(1)] <= res1;
    end
  end

  assign out_chan.valid       = (fill_r != '0);
  assign out_chan.token_kind  = q_r[rd_ptr_r].token_kind;
  assign out_chan.byte_value  = q_r[rd_ptr_r].byte_value;
  assign out_chan.word_length = q_r[rd_ptr_r].word_length;
  assign out_chan.last        = q_r[rd_ptr_r].last;

endmodule
